FILE: src/tti_pkg.sv
// Shared constants and helpers for the text-to-integer parser.
// No dependencies; used by text_to_integer_any_base.
`default_nettype none

package tti_pkg;

    // Upper limit on the radix; alphabets longer than this are rejected
    localparam int MAX_DIGITS  = 16;
    // Alphabet slots held in the two 64-bit character registers
    localparam int ALPHA_SLOTS = 16;

    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 5;
    localparam int VALUE_W   = 32;
    localparam int DIGIT_W   = 4;
    localparam int CFG_W     = 64;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 2;

    // Register indexes, decoded from paddr[4:3]
    localparam logic [REG_IDX_W-1:0] REG_DIGITS_LOW  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIGITS_HIGH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE_LENGTH = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Space, or tab through carriage return (tab, newline, vtab, form feed, CR)
    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // Characters that may not stand in the digit alphabet
    function automatic logic is_reserved(input logic [CHAR_W-1:0] c);
        return (c == CHAR_NUL) || (c == CHAR_PLUS) || (c == CHAR_MINUS) || is_space(c);
    endfunction

endpackage

`default_nettype wire

FILE: src/text_to_integer_any_base.sv
// A beat accepted into the input register is parsed as it leaves that register; on the
// last beat of a text the result is registered and presented on the master side.
// Throughput: one text byte per cycle; the accumulator multiply-add is the loop.
// A result held on the master side stalls only a following last beat.
// Reset (rst_n low, asynchronous) clears the control registers and the parse state.
// Streaming text-to-integer parser with a configurable digit alphabet.
// Depends on tti_pkg.
`default_nettype none

module text_to_integer_any_base
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // slave side
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] char_code
    input  wire logic                             s_tlast,   // end_of_text
    // master side
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [31:0]                           m_tdata,   // [31:0] parsed_value
    output logic                                  m_tuser,   // base_ok
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tti_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [tti_pkg::CFG_W-1:0]        pwdata,
    output logic [tti_pkg::CFG_W-1:0]             prdata,
    output logic                                  pready
);

    typedef enum logic [1:0] {PH_SPACE, PH_SIGN, PH_DIGIT, PH_FROZEN} phase_t;

    logic [tti_pkg::CFG_W-1:0]   chars_low_reg;
    logic [tti_pkg::CFG_W-1:0]   chars_high_reg;
    logic [tti_pkg::LEN_W-1:0]   base_length_reg;
    logic                        ok_reg;
    logic                        ok_next;

    logic                        s1_valid_reg;
    logic [tti_pkg::CHAR_W-1:0]  s1_char_reg;
    logic                        s1_last_reg;
    logic                        s1_fire;

    phase_t                      phase_reg;
    phase_t                      phase_next;
    logic                        neg_reg;
    logic                        neg_next;
    logic [tti_pkg::VALUE_W-1:0] acc_reg;
    logic [tti_pkg::VALUE_W-1:0] acc_next;
    logic [tti_pkg::VALUE_W-1:0] acc_mul;

    logic                        out_valid_reg;
    logic [tti_pkg::VALUE_W-1:0] out_value_reg;
    logic                        out_ok_reg;
    logic [tti_pkg::VALUE_W-1:0] result_value;

    logic [tti_pkg::CHAR_W-1:0]  alpha [tti_pkg::ALPHA_SLOTS];
    logic                        digit_hit;
    logic [tti_pkg::DIGIT_W-1:0] digit_val;

    logic                        cfg_write;
    logic [tti_pkg::REG_IDX_W-1:0] cfg_idx;
    logic                        out_free;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[tti_pkg::ADDR_W-1:3];

    always_comb
    begin
        unique case (cfg_idx)
            tti_pkg::REG_DIGITS_LOW:  prdata = chars_low_reg;
            tti_pkg::REG_DIGITS_HIGH: prdata = chars_high_reg;
            tti_pkg::REG_BASE_LENGTH:
                prdata = {{(tti_pkg::CFG_W-tti_pkg::LEN_W){1'b0}}, base_length_reg};
            default:                  prdata = '0;
        endcase
    end

    // Slot i of the alphabet; slots 8..15 come from the high register
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            alpha[i]     = chars_low_reg[i*8 +: 8];
            alpha[i + 8] = chars_high_reg[i*8 +: 8];
        end
    end

    // Alphabet check, registered; user must change config only while idle (not enforced)
    always_comb
    begin
        ok_next = (base_length_reg >= tti_pkg::LEN_W'(2)) &&
                  (base_length_reg <= tti_pkg::LEN_W'(tti_pkg::MAX_DIGITS));
        for (int i = 0; i < tti_pkg::ALPHA_SLOTS; i++)
        begin
            if (tti_pkg::LEN_W'(i) < base_length_reg)
            begin
                if (tti_pkg::is_reserved(alpha[i]))
                    ok_next = 1'b0;
                for (int j = i + 1; j < tti_pkg::ALPHA_SLOTS; j++)
                begin
                    if ((tti_pkg::LEN_W'(j) < base_length_reg) && (alpha[j] == alpha[i]))
                        ok_next = 1'b0;
                end
            end
        end
    end

    // Lowest matching slot within the radix
    always_comb
    begin
        digit_hit = 1'b0;
        digit_val = '0;
        for (int i = tti_pkg::ALPHA_SLOTS - 1; i >= 0; i--)
        begin
            if ((tti_pkg::LEN_W'(i) < base_length_reg) && (alpha[i] == s1_char_reg))
            begin
                digit_hit = 1'b1;
                digit_val = tti_pkg::DIGIT_W'(i);
            end
        end
        digit_hit = digit_hit && ok_reg;
    end

    assign acc_mul = acc_reg * {{(tti_pkg::VALUE_W-tti_pkg::LEN_W){1'b0}}, base_length_reg};

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (phase_reg != PH_FROZEN)
        begin
            if (s1_char_reg == tti_pkg::CHAR_NUL)
                phase_next = PH_FROZEN;
            else
            begin
                if ((phase_next == PH_SPACE) && !tti_pkg::is_space(s1_char_reg))
                    phase_next = PH_SIGN;
                if (phase_next == PH_SIGN)
                begin
                    if (s1_char_reg == tti_pkg::CHAR_MINUS)
                        neg_next = ~neg_reg;
                    else if (s1_char_reg != tti_pkg::CHAR_PLUS)
                        phase_next = PH_DIGIT;
                end
                if (phase_next == PH_DIGIT)
                begin
                    if (digit_hit)
                        acc_next = acc_mul +
                            {{(tti_pkg::VALUE_W-tti_pkg::DIGIT_W){1'b0}}, digit_val};
                    else
                        phase_next = PH_FROZEN;
                end
            end
        end
        if (!ok_reg)
            result_value = '0;
        else if (neg_next)
            result_value = '0 - acc_next;
        else
            result_value = acc_next;
    end

    // A last beat needs the result register free; others never stall
    assign out_free = !out_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign s_tready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_low_reg   <= '0;
            chars_high_reg  <= '0;
            base_length_reg <= '0;
            ok_reg          <= 1'b0;
            s1_valid_reg    <= 1'b0;
            phase_reg       <= PH_SPACE;
            neg_reg         <= 1'b0;
            acc_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_idx)
                    tti_pkg::REG_DIGITS_LOW:  chars_low_reg   <= pwdata;
                    tti_pkg::REG_DIGITS_HIGH: chars_high_reg  <= pwdata;
                    tti_pkg::REG_BASE_LENGTH: base_length_reg <= pwdata[tti_pkg::LEN_W-1:0];
                    default:                  ;
                endcase
            end
            ok_reg <= ok_next;

            if (s_tvalid && s_tready)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                if (s1_last_reg)
                begin
                    phase_reg <= PH_SPACE;
                    neg_reg   <= 1'b0;
                    acc_reg   <= '0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    acc_reg   <= acc_next;
                end
            end

            if (s1_fire && s1_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_char_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
        if (s1_fire && s1_last_reg)
        begin
            out_value_reg <= result_value;
            out_ok_reg    <= ok_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_ok_reg;

    // A new result only ever comes from a last beat leaving the input register
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result raised without a last beat");

    // A rejected alphabet always yields zero
    a_bad_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_value_reg == '0))
        else $error("non-zero value with invalid alphabet");

    // Digits accumulate only once the digit phase is reached
    a_acc_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg != '0) |-> ((phase_reg == PH_DIGIT) || (phase_reg == PH_FROZEN)))
        else $error("accumulator set outside digit phase");

    // Alphabet accepted only with a radix of at least two
    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        ok_reg |-> ($past(base_length_reg) >= tti_pkg::LEN_W'(2)))
        else $error("alphabet accepted with radix below two");

endmodule

`default_nettype wire

FILE: tb/sv/tti_parse_checker.sv
// Checker for text_to_integer_any_base: watches the text, result and register ports,
// predicts each parsed integer and compares it with what the block returns.
// Depends on tti_pkg.
`timescale 1ns / 1ps

module tti_parse_checker
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    input  wire logic                        s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] char_code
    input  wire logic                        s_tlast,   // end_of_text
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic [31:0]                 m_tdata,   // [31:0] parsed_value
    input  wire logic                        m_tuser,   // base_ok
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tti_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [tti_pkg::CFG_W-1:0]   pwdata,
    input  wire logic                        pready,
    output int                               errors,
    output int                               pending
);

    typedef enum logic [1:0] {SCAN_BLANK, SCAN_SIGN, SCAN_DIGIT, SCAN_FROZEN} scan_t;

    typedef struct packed {
        logic [tti_pkg::VALUE_W-1:0] value;
        logic                        base_ok;
    } parse_result_t;

    parse_result_t                result_q[$];

    // shadow of the register file, both character words side by side
    logic [127:0]                 alphabet = '0;
    logic [tti_pkg::LEN_W-1:0]    radix    = '0;

    scan_t                        scan     = SCAN_BLANK;
    logic                         negate   = 1'b0;
    logic [tti_pkg::VALUE_W-1:0]  acc      = '0;

    function automatic logic blank(input logic [7:0] c);
        return (c == tti_pkg::CHAR_SPACE) ||
               ((c >= tti_pkg::CHAR_TAB) && (c <= tti_pkg::CHAR_CR));
    endfunction

    function automatic logic alphabet_usable();
        logic [7:0] c;
        if ((radix < 2) || (radix > tti_pkg::MAX_DIGITS))
            return 1'b0;
        for (int i = 0; i < radix; i++)
        begin
            c = alphabet[i*8 +: 8];
            if ((c == tti_pkg::CHAR_NUL) || (c == tti_pkg::CHAR_PLUS) ||
                (c == tti_pkg::CHAR_MINUS) || blank(c))
                return 1'b0;
            for (int j = i + 1; j < radix; j++)
                if (alphabet[j*8 +: 8] == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int digit_index(input logic [7:0] c);
        for (int i = 0; (i < radix) && (i < tti_pkg::ALPHA_SLOTS); i++)
            if (alphabet[i*8 +: 8] == c)
                return i;
        return -1;
    endfunction

    task automatic parse_char(input logic [7:0] c, input logic last);
        logic          ok;
        int            d;
        parse_result_t res;
        ok = alphabet_usable();
        if (scan != SCAN_FROZEN)
        begin
            if (c == tti_pkg::CHAR_NUL)
                scan = SCAN_FROZEN;
            else
            begin
                if ((scan == SCAN_BLANK) && !blank(c))
                    scan = SCAN_SIGN;
                if (scan == SCAN_SIGN)
                begin
                    if (c == tti_pkg::CHAR_MINUS)
                        negate = ~negate;
                    else if (c != tti_pkg::CHAR_PLUS)
                        scan = SCAN_DIGIT;
                end
                if (scan == SCAN_DIGIT)
                begin
                    d = ok ? digit_index(c) : -1;
                    if (d >= 0)
                        acc = acc * {27'd0, radix} + tti_pkg::VALUE_W'(d);
                    else
                        scan = SCAN_FROZEN;
                end
            end
        end
        if (last)
        begin
            res.value   = ok ? (negate ? (32'd0 - acc) : acc) : '0;
            res.base_ok = ok;
            result_q.push_back(res);
            scan   = SCAN_BLANK;
            negate = 1'b0;
            acc    = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t exp_res;
        if (!rst_n)
        begin
            alphabet = '0;
            radix    = '0;
            scan     = SCAN_BLANK;
            negate   = 1'b0;
            acc      = '0;
            result_q.delete();
            pending <= 0;
        end
        else
        begin
            // results first: a beat taken at this edge cannot be the one leaving
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result beat with nothing expected: parsed_value %0d base_ok %0b",
                           $signed(m_tdata), m_tuser);
                    errors++;
                end
                else
                begin
                    exp_res = result_q.pop_front();
                    if (m_tdata !== exp_res.value)
                    begin
                        $error("parsed_value: expected %0d, got %0d",
                               $signed(exp_res.value), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tuser !== exp_res.base_ok)
                    begin
                        $error("base_ok: expected %0b, got %0b", exp_res.base_ok, m_tuser);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                parse_char(s_tdata, s_tlast);
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[tti_pkg::ADDR_W-1 -: tti_pkg::REG_IDX_W])
                    tti_pkg::REG_DIGITS_LOW:  alphabet[63:0]   = pwdata;
                    tti_pkg::REG_DIGITS_HIGH: alphabet[127:64] = pwdata;
                    tti_pkg::REG_BASE_LENGTH: radix            = pwdata[tti_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
            pending <= result_q.size();
        end
    end

endmodule

FILE: tb/sv/text_to_integer_any_base_tb.sv
// Top of the text_to_integer_any_base testbench: clock, reset, register writes,
// text streams with random gaps and a stalling result sink. Uses tti_parse_checker.
`timescale 1ns / 1ps

module text_to_integer_any_base_tb;

    localparam int ITEMS       = 1550;
    localparam int PHASE_ITEMS = 110;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 250000;

    localparam logic [127:0] HEX_DIGITS = {64'h4645_4443_4241_3938, 64'h3736_3534_3332_3130};

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata  = '0;
    logic                        s_tlast  = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [31:0]                 m_tdata;
    logic                        m_tuser;
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [tti_pkg::ADDR_W-1:0]  paddr    = '0;
    logic [tti_pkg::CFG_W-1:0]   pwdata   = '0;
    logic [tti_pkg::CFG_W-1:0]   prdata;
    logic                        pready;

    int                 errors;
    int                 pending;
    int                 cycles      = 0;
    int                 sent        = 0;
    int                 tx_idle_max = 10;
    int                 rx_idle_max = 10;

    // alphabet as last written, used to build digit runs
    logic [127:0]       alphabet = '0;
    int                 alen     = 0;
    logic [7:0]         text_buf[$];

    text_to_integer_any_base u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tti_parse_checker u_chk
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic bad_digit(input logic [7:0] c);
        return (c == tti_pkg::CHAR_NUL) || (c == tti_pkg::CHAR_PLUS) ||
               (c == tti_pkg::CHAR_MINUS) || (c == tti_pkg::CHAR_SPACE) ||
               ((c >= tti_pkg::CHAR_TAB) && (c <= tti_pkg::CHAR_CR));
    endfunction

    function automatic logic [7:0] pick_digit();
        int eff;
        eff = (alen > tti_pkg::ALPHA_SLOTS) ? tti_pkg::ALPHA_SLOTS : alen;
        if (eff == 0)
            return 8'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, eff - 1) * 8 +: 8];
    endfunction

    // distinct legal characters in the first len slots, anything in the rest
    task automatic make_alphabet(input int len, output logic [127:0] cat);
        logic [7:0] c;
        bit         used[256];
        for (int i = 0; i < tti_pkg::ALPHA_SLOTS; i++)
        begin
            if (i < len)
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (bad_digit(c) || used[c]);
                used[c] = 1'b1;
            end
            else
                c = 8'($urandom_range(0, 255));
            cat[i*8 +: 8] = c;
        end
    endtask

    // setup and access phases, then the bus is released
    task automatic apb_write(input logic [tti_pkg::REG_IDX_W-1:0] idx,
                             input logic [tti_pkg::CFG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_cfg(input logic [127:0] cat, input logic [tti_pkg::LEN_W-1:0] len);
        apb_write(tti_pkg::REG_DIGITS_LOW, cat[63:0]);
        apb_write(tti_pkg::REG_DIGITS_HIGH, cat[127:64]);
        apb_write(tti_pkg::REG_BASE_LENGTH, tti_pkg::CFG_W'(len));
        alphabet = cat;
        alen     = int'(len);
    endtask

    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        sent++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic flush_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    // drain every result, then give the pipeline time to empty
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // result sink: random ready gaps, one long hold-off to back up the input
    initial
    begin
        int gap;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 16 == 0)
                rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            gap = (taken == 12) ? HOLD_CYCLES : $urandom_range(0, rx_idle_max);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            taken++;
        end
    end

    initial
    begin
        logic [127:0]              cat;
        logic [tti_pkg::LEN_W-1:0] len;
        int                        phase_no;
        int                        start;
        int                        kind;
        int                        n;
        int                        a;
        int                        b;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: hexadecimal, full sixteen-character alphabet
        write_cfg(HEX_DIGITS, tti_pkg::LEN_W'(16));
        text_buf = '{tti_pkg::CHAR_TAB, 8'h0A, 8'h0B, 8'h0C, tti_pkg::CHAR_CR,
                     tti_pkg::CHAR_SPACE};
        push_str("-+-7F");
        flush_text();
        push_str("-FFFFFFFFF");         // wraps past 32 bits, then negated
        flush_text();
        text_buf.push_back(tti_pkg::CHAR_NUL);
        flush_text();
        push_str("5G3");                // frozen at G, trailing digit ignored
        flush_text();
        text_buf.push_back(8'hFF);
        flush_text();

        // radix changed part-way through a text
        send_byte("1", 1'b0);
        send_byte("2", 1'b0);
        settle();
        apb_write(tti_pkg::REG_BASE_LENGTH, tti_pkg::CFG_W'(2));
        alen = 2;
        send_byte("1", 1'b1);
        settle();

        // length beyond the slot count
        write_cfg(HEX_DIGITS, tti_pkg::LEN_W'(17));
        push_str("1");
        flush_text();
        settle();

        // NUL inside the alphabet
        cat = HEX_DIGITS;
        cat[3*8 +: 8] = tti_pkg::CHAR_NUL;
        write_cfg(cat, tti_pkg::LEN_W'(16));
        push_str("3");
        flush_text();
        settle();

        phase_no = 0;
        while (sent < ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (phase_no == 0)
            begin
                make_alphabet(2, cat);
                len = 2;
            end
            else if (phase_no == 1)
            begin
                make_alphabet(16, cat);
                len = 16;
            end
            else if (phase_no == 2)
            begin
                cat = '0;
                len = 0;
            end
            else if (phase_no == 3)
            begin
                cat = '1;
                len = 5'd31;
            end
            else if (kind < 6)
            begin
                len = tti_pkg::LEN_W'($urandom_range(2, 16));
                make_alphabet(len, cat);
            end
            else if (kind == 6)
            begin
                make_alphabet(16, cat);
                len = $urandom_range(0, 1) ? tti_pkg::LEN_W'($urandom_range(0, 1))
                                           : tti_pkg::LEN_W'($urandom_range(17, 31));
            end
            else if (kind == 7)
            begin
                len = tti_pkg::LEN_W'($urandom_range(2, 16));
                make_alphabet(len, cat);
                a = $urandom_range(0, len - 1);
                do
                    b = $urandom_range(0, len - 1);
                while (b == a);
                cat[b*8 +: 8] = cat[a*8 +: 8];
            end
            else if (kind == 8)
            begin
                len = tti_pkg::LEN_W'($urandom_range(2, 16));
                make_alphabet(len, cat);
                case ($urandom_range(0, 4))
                    0: cat[$urandom_range(0, len - 1)*8 +: 8] = tti_pkg::CHAR_NUL;
                    1: cat[$urandom_range(0, len - 1)*8 +: 8] = tti_pkg::CHAR_PLUS;
                    2: cat[$urandom_range(0, len - 1)*8 +: 8] = tti_pkg::CHAR_MINUS;
                    3: cat[$urandom_range(0, len - 1)*8 +: 8] = tti_pkg::CHAR_SPACE;
                    default: cat[$urandom_range(0, len - 1)*8 +: 8] =
                                 8'(tti_pkg::CHAR_TAB + $urandom_range(0, 4));
                endcase
            end
            else
            begin
                cat = $urandom_range(0, 1) ? '1 : '0;
                len = $urandom_range(0, 1) ? tti_pkg::LEN_W'(16) : tti_pkg::LEN_W'(2);
            end
            write_cfg(cat, len);
            tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 10;

            start = sent;
            while (sent - start < PHASE_ITEMS)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 7)
                begin
                    // blanks, signs, digits, then an optional tail
                    n = $urandom_range(0, 3);
                    repeat (n)
                        text_buf.push_back(($urandom_range(0, 5) == 0) ? tti_pkg::CHAR_SPACE
                                           : 8'(tti_pkg::CHAR_TAB + $urandom_range(0, 4)));
                    n = $urandom_range(0, 3);
                    repeat (n)
                        text_buf.push_back($urandom_range(0, 1) ? tti_pkg::CHAR_MINUS
                                                                : tti_pkg::CHAR_PLUS);
                    n = $urandom_range(0, 11);
                    repeat (n)
                        text_buf.push_back(pick_digit());
                    case ($urandom_range(0, 3))
                        1:
                        begin
                            text_buf.push_back(tti_pkg::CHAR_NUL);
                            text_buf.push_back(pick_digit());
                        end
                        2:
                        begin
                            text_buf.push_back(8'($urandom_range(0, 255)));
                            text_buf.push_back(pick_digit());
                        end
                        default: ;
                    endcase
                end
                else if (kind < 9)
                begin
                    n = $urandom_range(1, 8);
                    repeat (n)
                        text_buf.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    // sign or blank landing among the digits
                    n = $urandom_range(1, 4);
                    repeat (n)
                        text_buf.push_back(pick_digit());
                    case ($urandom_range(0, 2))
                        0:       text_buf.push_back(tti_pkg::CHAR_MINUS);
                        1:       text_buf.push_back(tti_pkg::CHAR_PLUS);
                        default: text_buf.push_back(tti_pkg::CHAR_SPACE);
                    endcase
                    n = $urandom_range(1, 4);
                    repeat (n)
                        text_buf.push_back(pick_digit());
                end
                if (text_buf.size() == 0)
                    text_buf.push_back(8'($urandom_range(0, 255)));
                flush_text();
            end
            settle();
            phase_no++;
        end

        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
